// ===== design/oahs_pkg.sv =====
package oahs_pkg;

  localparam int unsigned KEY_BITS    = 64;
  localparam int unsigned HASH_BITS   = 64;
  localparam int unsigned SLOT_IDX_W  = 10;
  localparam int unsigned MAX_SLOTS   = 1 << SLOT_IDX_W;
  localparam int unsigned MAX_ENTRIES = (MAX_SLOTS * 2) / 3;
  localparam int unsigned ENT_IDX_W   = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned CODE_W      = 11;
  localparam int unsigned LG_W        = 5;
  localparam int unsigned STEP_W      = 11;

  localparam logic [LG_W-1:0]   SLOT_LG_MIN = LG_W'(3);
  localparam logic [LG_W-1:0]   SLOT_LG_MAX = LG_W'(SLOT_IDX_W);
  localparam logic [CODE_W-1:0] SLOT_EMPTY  = {CODE_W{1'b1}};
  localparam logic [CODE_W-1:0] SLOT_TOMB   = {{(CODE_W-1){1'b1}}, 1'b0};

  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_CONTAINS = 3'd1,
    MODE_DISCARD  = 3'd2,
    MODE_POP      = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_POP_EMPTY = 3'd5,
    ST_FULL      = 3'd6,
    ST_CLEARED   = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0]           mode;
    logic [KEY_BITS-1:0]  key_value;
    logic [HASH_BITS-1:0] key_hash;
  } in_req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [KEY_BITS-1:0] key_out;
    logic [CNT_W-1:0]    live_count;
  } out_rsp_t;

  typedef struct packed {
    logic                 start;
    logic                 adv;
    logic [HASH_BITS-1:0] hash;
    logic [LG_W-1:0]      lg;
  } probe_ctrl_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] idx;
    logic                  last;
  } probe_stat_t;

  function automatic logic [SLOT_IDX_W-1:0] slot_mask(input logic [LG_W-1:0] lg);
    logic [SLOT_IDX_W:0] s;
    s = (SLOT_IDX_W+1)'(1) << lg;
    return SLOT_IDX_W'(s - (SLOT_IDX_W+1)'(1));
  endfunction

  // two thirds of the slot count
  function automatic logic [CNT_W-1:0] usable_of(input logic [LG_W-1:0] lg);
    logic [CNT_W-1:0] u;
    case (lg)
      LG_W'(3):  u = CNT_W'((8 * 2) / 3);
      LG_W'(4):  u = CNT_W'((16 * 2) / 3);
      LG_W'(5):  u = CNT_W'((32 * 2) / 3);
      LG_W'(6):  u = CNT_W'((64 * 2) / 3);
      LG_W'(7):  u = CNT_W'((128 * 2) / 3);
      LG_W'(8):  u = CNT_W'((256 * 2) / 3);
      LG_W'(9):  u = CNT_W'((512 * 2) / 3);
      default:   u = CNT_W'(MAX_ENTRIES);
    endcase
    return u;
  endfunction

  // smallest table from 8 slots up that is larger than 3*live
  function automatic logic [LG_W-1:0] grow_lg(input logic [CNT_W-1:0] live);
    logic [CNT_W+2:0] m3;
    logic [LG_W-1:0]  lg;
    m3 = {1'b0, live, 2'b0} - (CNT_W+3)'(live);
    lg = SLOT_LG_MIN;
    for (int k = 3; k <= CNT_W + 2; k++) begin
      if (((CNT_W+3)'(1) << k) <= m3) lg = LG_W'(k + 1);
    end
    return lg;
  endfunction

endpackage

// ===== design/ordered_open_addressing_hash_set.sv =====
// each probed slot passes S_P_RD and S_P_CHK (and S_P_ENT when the slot holds an entry), then
// a decision state (S_HIT or S_MISS) and the response state S_RESP follow
// pop passes S_POP_RD and S_POP_CHK for each dead entry skipped at the head of the entry store
// an add that grows the table adds a rebuild: compaction (S_C_RD, S_C_WR per used entry),
// a slot memory sweep over the new slots (S_CLR) and a probe for each live entry reinserted
// one request in flight at a time; a stalled response holds
// the next request back
// reset: control cleared, then a sweep marks the 8 active slots empty before requests
module ordered_open_addressing_hash_set import oahs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_data_o
);

  typedef enum logic [14:0] {
    S_CLR     = 15'h0001,
    S_IDLE    = 15'h0002,
    S_P_RD    = 15'h0004,
    S_P_CHK   = 15'h0008,
    S_P_ENT   = 15'h0010,
    S_HIT     = 15'h0020,
    S_MISS    = 15'h0040,
    S_C_RD    = 15'h0080,
    S_C_WR    = 15'h0100,
    S_RB_RD   = 15'h0200,
    S_RB_H    = 15'h0400,
    S_POP_RD  = 15'h0800,
    S_POP_CHK = 15'h1000,
    S_POP_KEY = 15'h2000,
    S_RESP    = 15'h4000
  } state_e;

  // where the slot sweep goes when done
  typedef enum logic [1:0] {
    RET_IDLE = 2'd0,
    RET_RESP = 2'd1,
    RET_RB   = 2'd2
  } clr_ret_e;

  state_e   state_q, state_d;
  clr_ret_e ret_q, ret_d;
  mode_e    op_q, op_d;

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [HASH_BITS-1:0]  hash_q, hash_d;
  logic [CNT_W-1:0]      used_q, used_d, live_q, live_d;
  logic [LG_W-1:0]       lg_q, lg_d, newlg_q, newlg_d, grow;
  logic [CNT_W-1:0]      r_q, r_d, w_q, w_d;
  logic [SLOT_IDX_W-1:0] clr_q, clr_d, ff_q, ff_d;
  logic                  ffv_q, ffv_d;
  logic [ENT_IDX_W-1:0]  hit_ix_q, hit_ix_d;
  logic                  rb_ins_q, rb_ins_d, reprobe_q, reprobe_d;
  status_e               res_status_q, res_status_d;
  logic [KEY_BITS-1:0]   res_key_q, res_key_d;
  out_rsp_t              out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  // slot table: entry index, or the empty / tombstone codes
  logic [CODE_W-1:0]     slot_mem [MAX_SLOTS];
  logic [SLOT_IDX_W-1:0] slot_ra, slot_wa;
  logic [CODE_W-1:0]     slot_wd, slot_rd_q;
  logic                  slot_we;

  // insertion-ordered entry store {key, hash} and its live bits
  logic [KEY_BITS+HASH_BITS-1:0] ent_mem [MAX_ENTRIES];
  logic                          live_mem [MAX_ENTRIES];
  logic [ENT_IDX_W-1:0]          ent_ra, ent_wa, live_wa;
  logic [KEY_BITS+HASH_BITS-1:0] ent_wd, ent_rd_q;
  logic                          ent_we, live_we, live_wd, live_rd_q;

  probe_ctrl_t pc;
  probe_stat_t pst;

  oahs_probe_seq u_probe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (pc),
    .stat_o (pst)
  );

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_q <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (live_we) live_mem[live_wa] <= live_wd;
    ent_rd_q  <= ent_mem[ent_ra];
    live_rd_q <= live_mem[ent_ra];
  end

  assign grow = grow_lg(live_q);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    op_d         = op_q;
    key_d        = key_q;
    hash_d       = hash_q;
    used_d       = used_q;
    live_d       = live_q;
    lg_d         = lg_q;
    newlg_d      = newlg_q;
    r_d          = r_q;
    w_d          = w_q;
    clr_d        = clr_q;
    ff_d         = ff_q;
    ffv_d        = ffv_q;
    hit_ix_d     = hit_ix_q;
    rb_ins_d     = rb_ins_q;
    reprobe_d    = reprobe_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    slot_we = 1'b0;
    slot_wa = pst.idx;
    slot_wd = SLOT_EMPTY;
    slot_ra = pst.idx;
    ent_we  = 1'b0;
    ent_wa  = w_q[ENT_IDX_W-1:0];
    ent_wd  = ent_rd_q;
    live_we = 1'b0;
    live_wa = w_q[ENT_IDX_W-1:0];
    live_wd = 1'b1;
    ent_ra  = r_q[ENT_IDX_W-1:0];

    pc.start = 1'b0;
    pc.adv   = 1'b0;
    pc.hash  = hash_q;
    pc.lg    = lg_q;

    unique case (state_q)
      // mark the active slots empty
      S_CLR: begin
        slot_we = 1'b1;
        slot_wa = clr_q;
        slot_wd = SLOT_EMPTY;
        clr_d   = clr_q + SLOT_IDX_W'(1);
        if (clr_q == slot_mask(lg_q)) begin
          clr_d = '0;
          unique case (ret_q)
            RET_IDLE: state_d = S_IDLE;
            RET_RESP: state_d = S_RESP;
            RET_RB: begin
              r_d      = '0;
              rb_ins_d = 1'b1;
              state_d  = S_RB_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = mode_e'(in_data_i.mode);
          key_d     = in_data_i.key_value;
          hash_d    = in_data_i.key_hash;
          res_key_d = '0;
          reprobe_d = 1'b0;
          rb_ins_d  = 1'b0;
          ffv_d     = 1'b0;
          case (in_data_i.mode) inside
            MODE_ADD, MODE_CONTAINS, MODE_DISCARD: begin
              pc.start = 1'b1;
              pc.hash  = in_data_i.key_hash;
              state_d  = S_P_RD;
            end
            MODE_POP: begin
              r_d = '0;
              if (live_q == '0) begin
                res_status_d = ST_POP_EMPTY;
                state_d      = S_RESP;
              end else begin
                state_d = S_POP_RD;
              end
            end
            MODE_CLEAR: begin
              lg_d         = SLOT_LG_MIN;
              used_d       = '0;
              live_d       = '0;
              clr_d        = '0;
              ret_d        = RET_RESP;
              res_status_d = ST_CLEARED;
              state_d      = S_CLR;
            end
            default: begin
              res_status_d = ST_ABSENT;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      // slot read issued at the probe index
      S_P_RD: begin
        slot_ra = pst.idx;
        state_d = S_P_CHK;
      end

      S_P_CHK: begin
        if (slot_rd_q == SLOT_EMPTY) begin
          if (rb_ins_q) begin
            slot_we = 1'b1;
            slot_wa = pst.idx;
            slot_wd = CODE_W'(r_q);
            r_d     = r_q + CNT_W'(1);
            state_d = S_RB_RD;
          end else begin
            if (!ffv_q) ff_d = pst.idx;
            ffv_d   = 1'b1;
            state_d = S_MISS;
          end
        end else if (!rb_ins_q && slot_rd_q != SLOT_TOMB &&
                     slot_rd_q < CODE_W'(used_q)) begin
          ent_ra   = slot_rd_q[ENT_IDX_W-1:0];
          hit_ix_d = slot_rd_q[ENT_IDX_W-1:0];
          state_d  = S_P_ENT;
        end else begin
          // first tombstone is the insert spot
          if (!rb_ins_q && slot_rd_q == SLOT_TOMB && !ffv_q) begin
            ff_d  = pst.idx;
            ffv_d = 1'b1;
          end
          if (pst.last) begin
            if (rb_ins_q) begin
              r_d     = r_q + CNT_W'(1);
              state_d = S_RB_RD;
            end else begin
              state_d = S_MISS;
            end
          end else begin
            pc.adv  = 1'b1;
            state_d = S_P_RD;
          end
        end
      end

      S_P_ENT: begin
        if (live_rd_q && ent_rd_q[KEY_BITS+HASH_BITS-1:HASH_BITS] == key_q) begin
          state_d = S_HIT;
        end else if (pst.last) begin
          state_d = S_MISS;
        end else begin
          pc.adv  = 1'b1;
          state_d = S_P_RD;
        end
      end

      S_HIT: begin
        state_d = S_RESP;
        case (op_q) inside
          MODE_CONTAINS: res_status_d = ST_FOUND;
          MODE_DISCARD, MODE_POP: begin
            slot_we = 1'b1;
            slot_wa = pst.idx;
            slot_wd = SLOT_TOMB;
            live_we = 1'b1;
            live_wa = hit_ix_q;
            live_wd = 1'b0;
            if (live_q != '0) live_d = live_q - CNT_W'(1);
            res_status_d = ST_REMOVED;
            if (op_q == MODE_POP) res_key_d = key_q;
          end
          default: res_status_d = ST_PRESENT;
        endcase
      end

      S_MISS: begin
        state_d = S_RESP;
        case (op_q) inside
          MODE_CONTAINS, MODE_DISCARD: res_status_d = ST_ABSENT;
          MODE_POP: res_status_d = ST_POP_EMPTY;
          default: begin
            if (!reprobe_q && used_q >= usable_of(lg_q)) begin
              // table too loaded: grow and rebuild, or report full
              if (grow > SLOT_LG_MAX) begin
                res_status_d = ST_FULL;
              end else begin
                newlg_d   = grow;
                reprobe_d = 1'b1;
                r_d       = '0;
                w_d       = '0;
                state_d   = S_C_RD;
              end
            end else if (!ffv_q || used_q >= CNT_W'(MAX_ENTRIES)) begin
              res_status_d = ST_FULL;
            end else begin
              slot_we = 1'b1;
              slot_wa = ff_q;
              slot_wd = CODE_W'(used_q);
              ent_we  = 1'b1;
              ent_wa  = used_q[ENT_IDX_W-1:0];
              ent_wd  = {key_q, hash_q};
              live_we = 1'b1;
              live_wa = used_q[ENT_IDX_W-1:0];
              live_wd = 1'b1;
              used_d  = used_q + CNT_W'(1);
              live_d  = live_q + CNT_W'(1);
              res_status_d = ST_INSERTED;
            end
          end
        endcase
      end

      // compaction: copy live entries down in order
      S_C_RD: begin
        if (r_q >= used_q) begin
          used_d  = w_q;
          live_d  = w_q;
          lg_d    = newlg_q;
          clr_d   = '0;
          ret_d   = RET_RB;
          state_d = S_CLR;
        end else begin
          ent_ra  = r_q[ENT_IDX_W-1:0];
          state_d = S_C_WR;
        end
      end

      S_C_WR: begin
        if (live_rd_q) begin
          ent_we  = 1'b1;
          ent_wa  = w_q[ENT_IDX_W-1:0];
          ent_wd  = ent_rd_q;
          live_we = 1'b1;
          live_wa = w_q[ENT_IDX_W-1:0];
          live_wd = 1'b1;
          w_d     = w_q + CNT_W'(1);
        end
        r_d     = r_q + CNT_W'(1);
        state_d = S_C_RD;
      end

      // reinsert each entry into the fresh table, then probe the request key again
      S_RB_RD: begin
        if (r_q >= used_q) begin
          rb_ins_d = 1'b0;
          ffv_d    = 1'b0;
          pc.start = 1'b1;
          pc.hash  = hash_q;
          state_d  = S_P_RD;
        end else begin
          ent_ra  = r_q[ENT_IDX_W-1:0];
          state_d = S_RB_H;
        end
      end

      S_RB_H: begin
        pc.start = 1'b1;
        pc.hash  = ent_rd_q[HASH_BITS-1:0];
        state_d  = S_P_RD;
      end

      // pop: find the oldest live entry
      S_POP_RD: begin
        if (r_q >= used_q) begin
          res_status_d = ST_POP_EMPTY;
          state_d      = S_RESP;
        end else begin
          ent_ra  = r_q[ENT_IDX_W-1:0];
          state_d = S_POP_CHK;
        end
      end

      S_POP_CHK: begin
        if (live_rd_q) begin
          ent_ra  = r_q[ENT_IDX_W-1:0];
          state_d = S_POP_KEY;
        end else begin
          r_d     = r_q + CNT_W'(1);
          state_d = S_POP_RD;
        end
      end

      S_POP_KEY: begin
        key_d    = ent_rd_q[KEY_BITS+HASH_BITS-1:HASH_BITS];
        hash_d   = ent_rd_q[HASH_BITS-1:0];
        ffv_d    = 1'b0;
        pc.start = 1'b1;
        pc.hash  = ent_rd_q[HASH_BITS-1:0];
        state_d  = S_P_RD;
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status     = res_status_q;
          out_d.key_out    = res_key_q;
          out_d.live_count = live_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ret_q       <= RET_IDLE;
      used_q      <= '0;
      live_q      <= '0;
      lg_q        <= SLOT_LG_MIN;
      clr_q       <= '0;
      ffv_q       <= 1'b0;
      rb_ins_q    <= 1'b0;
      reprobe_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      used_q      <= used_d;
      live_q      <= live_d;
      lg_q        <= lg_d;
      clr_q       <= clr_d;
      ffv_q       <= ffv_d;
      rb_ins_q    <= rb_ins_d;
      reprobe_q   <= reprobe_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request payload and working registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    hash_q       <= hash_d;
    newlg_q      <= newlg_d;
    r_q          <= r_d;
    w_q          <= w_d;
    ff_q         <= ff_d;
    hit_ix_q     <= hit_ix_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/oahs_probe_seq.sv =====
module oahs_probe_seq import oahs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  probe_ctrl_t ctrl_i,
  output probe_stat_t stat_o
);

  logic [SLOT_IDX_W-1:0] idx_q, idx_d, mask;
  logic [HASH_BITS-1:0]  pert_q, pert_d, pert_nx;
  logic [STEP_W-1:0]     n_q, n_d;
  logic [STEP_W:0]       guard_lim;

  assign mask      = slot_mask(ctrl_i.lg);
  assign pert_nx   = pert_q >> 5;
  assign guard_lim = ((STEP_W+1)'(1) << ctrl_i.lg) + (STEP_W+1)'(16);

  always_comb begin
    idx_d  = idx_q;
    pert_d = pert_q;
    n_d    = n_q;
    if (ctrl_i.start) begin
      idx_d  = ctrl_i.hash[SLOT_IDX_W-1:0] & mask;
      pert_d = ctrl_i.hash;
      n_d    = '0;
    end else if (ctrl_i.adv) begin
      idx_d  = ({idx_q[SLOT_IDX_W-3:0], 2'b00} + idx_q + pert_nx[SLOT_IDX_W-1:0]
               + SLOT_IDX_W'(1)) & mask;
      pert_d = pert_nx;
      n_d    = n_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pert_q <= '0;
      n_q    <= '0;
    end else begin
      idx_q  <= idx_d;
      pert_q <= pert_d;
      n_q    <= n_d;
    end
  end

  assign stat_o.idx  = idx_q;
  assign stat_o.last = ({1'b0, n_q} + (STEP_W+1)'(1)) >= guard_lim;

endmodule

// ===== design/oahs_checker.sv =====
module oahs_checker import oahs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_req_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.live_count <= CNT_W'(MAX_ENTRIES))
    else $error("live count above store depth");

  a_cleared_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_CLEARED |->
      out_data_o.live_count == '0 && out_data_o.key_out == '0)
    else $error("clear left live keys");

  a_key_only_on_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_out != '0 |-> out_data_o.status == ST_REMOVED)
    else $error("key out without removal");

endmodule

bind ordered_open_addressing_hash_set oahs_checker u_oahs_checker (.*);
